// ===== rtl/word_dictionary_table_core_assert.svh =====
// Assertion macros for the checker file of the word dictionary table.
// No dependencies; take in with `include before use.
`ifndef WORD_DICTIONARY_TABLE_CORE_ASSERT_SVH
`define WORD_DICTIONARY_TABLE_CORE_ASSERT_SVH

// Clocked assertion, switched off while reset is high.
`define WDT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define WDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wdt_pkg.sv =====
// Shared constants, opcodes, types and key normalisation for the word dictionary table.
// No dependencies.
`default_nettype none

package wdt_pkg;

   localparam int DICT_SIZE      = 64;
   localparam int MAX_WORD_CHARS = 8;

   localparam int KEY_W = 64;
   localparam int OP_W  = 3;
   localparam int OUT_W = 7;
   localparam int IDX_W = (DICT_SIZE > 1) ? $clog2(DICT_SIZE) : 1;
   localparam int CNT_W = $clog2(DICT_SIZE + 1);

   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
   localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic scan_step;
      logic wr_insert;
      logic wr_update;
      logic rd_last;
      logic wr_delete;
      logic clr_count;
      logic finish;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            scan_done;
      logic            found;
      logic            is_full;
      logic            rsp_busy;
   } status_type;

   // Cut a key at its first zero byte and after MAX_WORD_CHARS characters.
   function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      logic             alive;
      r     = '0;
      alive = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (i >= MAX_WORD_CHARS) alive = 1'b0;
         if (k[KEY_W-1-8*i -: 8] == 8'h00) alive = 1'b0;
         if (alive) r[KEY_W-1-8*i -: 8] = k[KEY_W-1-8*i -: 8];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/wdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wdt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/wdt_datapath.sv =====
// Datapath: key registers, entry count, scan pointer, word store and result register.
// Depends on wdt_pkg and wdt_ram.
`default_nettype none

module wdt_datapath import wdt_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   output status_type            status,
   input  wire logic [OP_W-1:0]  req_opcode,
   input  wire logic [KEY_W-1:0] req_word_key,
   input  wire logic [KEY_W-1:0] req_new_word_key,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [OUT_W-1:0] rsp_result_value,
   output logic                  rsp_table_full,
   output logic      [OUT_W-1:0] rsp_entry_count
);

   logic [OP_W-1:0]  op_ff;
   logic [KEY_W-1:0] key_ff, key2_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_idx_ff;
   logic [IDX_W-1:0] cmp_idx_ff, pos_ff;
   logic             pending_ff, found_ff;
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] res_ff, cnt_out_ff;
   logic             full_ff;

   logic             we, re;
   logic [IDX_W-1:0] waddr, raddr;
   logic [KEY_W-1:0] wdata, rdata;
   logic             hit, issue, is_full;
   logic [CNT_W-1:0] count_dec, count_inc;
   logic [CNT_W-1:0] res_val, cnt_val;
   logic             full_val;

   assign count_dec = count_ff - CNT_W'(1);
   assign count_inc = count_ff + CNT_W'(1);
   assign is_full   = (count_ff == CNT_W'(DICT_SIZE));
   assign hit       = pending_ff && (rdata == key_ff);
   assign issue     = (scan_idx_ff < count_ff);

   // Word store access.
   assign re    = (cmd.scan_step && issue) || cmd.rd_last;
   assign raddr = cmd.rd_last ? count_dec[IDX_W-1:0] : scan_idx_ff[IDX_W-1:0];
   assign we    = cmd.wr_insert || cmd.wr_update || cmd.wr_delete;
   assign waddr = cmd.wr_insert ? count_ff[IDX_W-1:0] : pos_ff;
   always_comb begin
      if (cmd.wr_insert)      wdata = key_ff;
      else if (cmd.wr_update) wdata = key2_ff;
      else                    wdata = rdata;
   end

   wdt_ram #(.WIDTH(KEY_W), .DEPTH(DICT_SIZE), .AW(IDX_W)) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Result of the current item, taken from the count before this cycle's update.
   always_comb begin
      res_val  = '0;
      full_val = 1'b0;
      cnt_val  = count_ff;
      case (op_ff)
         OP_CLEAR: begin
            res_val = CNT_W'(1);
            cnt_val = '0;
         end
         OP_INSERT: begin
            if (!found_ff && is_full) begin
               full_val = 1'b1;
            end else if (!found_ff) begin
               res_val = count_inc;
               cnt_val = count_inc;
            end
         end
         OP_DELETE: begin
            if (found_ff) begin
               res_val = CNT_W'(1);
               cnt_val = count_dec;
            end
         end
         OP_LOOKUP, OP_UPDATE: res_val = CNT_W'(found_ff);
         default: res_val = '0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clr_count)      count_in = '0;
      else if (cmd.wr_insert) count_in = count_inc;
      else if (cmd.wr_delete) count_in = count_dec;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.finish)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_opcode;
         key_ff      <= normalize_key(req_word_key);
         key2_ff     <= normalize_key(req_new_word_key);
         scan_idx_ff <= '0;
         pending_ff  <= 1'b0;
         found_ff    <= 1'b0;
      end else if (cmd.scan_step) begin
         if (hit) begin
            found_ff   <= 1'b1;
            pos_ff     <= cmp_idx_ff;
            pending_ff <= 1'b0;
         end else if (issue) begin
            pending_ff  <= 1'b1;
            cmp_idx_ff  <= scan_idx_ff[IDX_W-1:0];
            scan_idx_ff <= scan_idx_ff + CNT_W'(1);
         end else begin
            pending_ff <= 1'b0;
         end
      end
      if (cmd.finish) begin
         res_ff     <= OUT_W'(res_val);
         full_ff    <= full_val;
         cnt_out_ff <= OUT_W'(cnt_val);
      end
   end

   assign status.op        = op_ff;
   assign status.scan_done = hit || (!pending_ff && !issue);
   assign status.found     = found_ff;
   assign status.is_full   = is_full;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = res_ff;
   assign rsp_table_full   = full_ff;
   assign rsp_entry_count  = cnt_out_ff;

endmodule

`default_nettype wire

// ===== rtl/wdt_controller.sv =====
// Controller: sequences accept, scan, commit and result for one item at a time.
// Depends on wdt_pkg.
`default_nettype none

module wdt_controller import wdt_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ACT,
      S_DEL_WR
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (status.op inside {OP_INSERT, OP_DELETE, OP_LOOKUP, OP_UPDATE}) begin
               cmd.scan_step = 1'b1;
               if (status.scan_done) state_in = S_ACT;
            end else begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            // hold until the result register is free
            if (!status.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
               case (status.op)
                  OP_CLEAR:  cmd.clr_count = 1'b1;
                  OP_INSERT: cmd.wr_insert = !status.found && !status.is_full;
                  OP_DELETE: begin
                     if (status.found) begin
                        cmd.finish  = 1'b0;
                        cmd.rd_last = 1'b1;
                        state_in    = S_DEL_WR;
                     end
                  end
                  OP_UPDATE: cmd.wr_update = status.found;
                  default:   cmd.finish = 1'b1;
               endcase
            end
         end
         S_DEL_WR: begin
            cmd.wr_delete = 1'b1;
            cmd.finish    = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

// ===== rtl/word_dictionary_table_core.sv =====
// Top level of the word dictionary table: controller plus datapath.
// Depends on wdt_pkg, wdt_controller, wdt_datapath (and wdt_ram below it).
//
//  - req channel (valid/ready) carries one item: opcode, word_key, new_word_key.
//    Keys are up to eight ASCII characters, first in the top byte, cut at the
//    first zero byte. Opcodes: clear, insert, delete, lookup, update.
//  - rsp channel (valid/ready) returns one item per request: result_value,
//    table_full and entry_count after the operation.
//  - A search scans the entries below the count in order and ends at a hit;
//    clear and unused opcodes skip it. The scan does one word store read a
//    cycle, each compared in the cycle after its read.
//  - One item in flight; req_ready is high only while idle, so the next item can
//    be taken in the cycle in which rsp_valid rises.
//  - Reset clears the entry count and the result valid flag; the word store is
//    not cleared, since only entries below the count are read.
//  - When the receiver stalls, hold the result in its register and accept a new
//    item; it completes its scan, then waits to commit until the result is taken.
`default_nettype none

module word_dictionary_table_core import wdt_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [OP_W-1:0]  req_opcode,
   input  wire logic [KEY_W-1:0] req_word_key,
   input  wire logic [KEY_W-1:0] req_new_word_key,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [OUT_W-1:0] rsp_result_value,
   output logic                  rsp_table_full,
   output logic      [OUT_W-1:0] rsp_entry_count
);

   cmd_type    cmd;
   status_type status;

   // Sequencing: accept, scan, commit, present result.
   wdt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage, compare and result formation.
   wdt_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_word_key     (req_word_key),
      .req_new_word_key (req_new_word_key),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_table_full   (rsp_table_full),
      .rsp_entry_count  (rsp_entry_count)
   );

endmodule

`default_nettype wire

// ===== rtl/wdt_checker.sv =====
// Port-level checks for the word dictionary table, bound to the top level.
// Depends on wdt_pkg and word_dictionary_table_core_assert.svh.
`default_nettype none
`include "word_dictionary_table_core_assert.svh"

module wdt_checker import wdt_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic [OP_W-1:0]  req_opcode,
   input wire logic [KEY_W-1:0] req_word_key,
   input wire logic [KEY_W-1:0] req_new_word_key,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [OUT_W-1:0] rsp_result_value,
   input wire logic             rsp_table_full,
   input wire logic [OUT_W-1:0] rsp_entry_count
);

   `WDT_ASSERT(a_req_hold, clock, reset,
      req_valid && !req_ready |=> req_valid && $stable(req_opcode)
         && $stable(req_word_key) && $stable(req_new_word_key),
      "request changed while waiting")
   `WDT_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_table_full) && $stable(rsp_entry_count),
      "result changed while stalled")
   `WDT_ASSERT(a_busy_after_accept, clock, reset,
      req_valid && req_ready |=> !req_ready,
      "item accepted while another is in flight")
   `WDT_ASSERT(a_full_means_refused, clock, reset,
      rsp_valid && rsp_table_full |-> rsp_result_value == '0,
      "full flag with a nonzero result")
   `WDT_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid,
      "result pending after reset")

endmodule

bind word_dictionary_table_core wdt_checker u_wdt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_opcode       (req_opcode),
   .req_word_key     (req_word_key),
   .req_new_word_key (req_new_word_key),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_table_full   (rsp_table_full),
   .rsp_entry_count  (rsp_entry_count)
);

`default_nettype wire
